// ===== rtl/gorilla_xor_value_encoder_defines.svh =====
// assertion macros used by the gorilla xor value encoder checker
`ifndef GORILLA_XOR_VALUE_ENCODER_DEFINES_SVH
`define GORILLA_XOR_VALUE_ENCODER_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define GXVE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is held
`define GXVE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/gxve_pkg.sv =====
// types and constants of the gorilla xor value encoder
`timescale 1ns / 1ps

package gxve_pkg;

  localparam int WORD_BITS    = 64;
  localparam int LEAD_W       = 6;
  localparam int COUNT_W      = 7;
  localparam int ELEM_BYTES_W = 4;
  localparam int MAX_BYTES    = 8;
  localparam int OUT_USER_W   = 3;
  localparam int OUT_FIELDS_W = LEAD_W + COUNT_W + WORD_BITS;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

  localparam logic [ELEM_BYTES_W-1:0] ELEM_BYTES_RESET = ELEM_BYTES_W'(MAX_BYTES);
  localparam logic [COUNT_W-1:0]      FULL_COUNT       = COUNT_W'(WORD_BITS);

  typedef struct packed {
    logic                 raw_first;
    logic                 changed;
    logic                 new_window;
    logic [LEAD_W-1:0]    leading_zeros;
    logic [COUNT_W-1:0]   bit_count;
    logic [WORD_BITS-1:0] payload;
  } result_t;

endpackage

// ===== rtl/gorilla_xor_value_encoder.sv =====
// Gorilla XOR value encoder: streams one value per beat and gives one coded result per beat.
// The block accepts one value beat every clock cycle and offers its result from the result
// register: the masked value is held in an input register, then the XOR with the
// previous value, the leading and trailing zero counts, the window check and the payload
// shift are all worked out in one pass into the result register. Throughput is one beat
// per cycle as long as the result side keeps taking beats; a stall on out_tready holds
// the result register and then the input register. The previous value and the stored
// window advance as each result is written, so back-to-back beats see each other's
// state. in_tready is low while rst_n is held.
// cfg_wr_data sets the element size in bytes (reset 8, above 8 counts as 8, 0 masks
// every value to zero); write it only while no beat is in flight.
`timescale 1ns / 1ps

module gorilla_xor_value_encoder (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration
  input  logic                                 cfg_wr_en,
  input  logic [gxve_pkg::ELEM_BYTES_W-1:0]    cfg_wr_data,  // element_bytes
  // value stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [gxve_pkg::WORD_BITS-1:0]       in_tdata,     // value
  input  logic                                 in_tuser,     // block_start
  // result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // leading_zeros [5:0], bit_count [12:6], payload [76:13], zero pad [79:77]
  output logic [gxve_pkg::OUT_DATA_W-1:0]      out_tdata,
  // raw_first [0], changed [1], new_window [2]
  output logic [gxve_pkg::OUT_USER_W-1:0]      out_tuser
);

  localparam int WB = gxve_pkg::WORD_BITS;
  localparam int LW = gxve_pkg::LEAD_W;
  localparam int CW = gxve_pkg::COUNT_W;

  logic [gxve_pkg::ELEM_BYTES_W-1:0] elem_bytes_r;
  logic [gxve_pkg::ELEM_BYTES_W-1:0] bytes_clamped;
  logic [WB-1:0]                     value_mask;

  logic          s1_valid_r;
  logic [WB-1:0] s1_value_r;
  logic          s1_start_r;

  logic                  out_valid_r;
  gxve_pkg::result_t     res_r;
  gxve_pkg::result_t     res_nxt;

  logic [WB-1:0] prev_value_r, prev_value_nxt;
  logic [LW-1:0] win_lead_r, win_lead_nxt;
  logic [CW-1:0] win_bits_r, win_bits_nxt;

  logic          s2_ready;
  logic          s1_load;
  logic          s2_adv;

  logic [WB-1:0] xor_val;
  logic [LW-1:0] lead;
  logic [LW-1:0] trail;
  logic [CW-1:0] mbits;
  logic [CW-1:0] top_end;
  logic [CW-1:0] win_end;
  logic [CW-1:0] reuse_shift;
  logic          fits;

  assign s2_ready  = !out_valid_r || out_tready;
  assign in_tready = rst_n && (!s1_valid_r || s2_ready);
  assign s1_load   = in_tvalid && in_tready;
  assign s2_adv    = s1_valid_r && s2_ready;

  // element width mask, one byte lane at a time
  always_comb begin
    bytes_clamped = (elem_bytes_r > gxve_pkg::ELEM_BYTES_W'(gxve_pkg::MAX_BYTES)) ?
                    gxve_pkg::ELEM_BYTES_W'(gxve_pkg::MAX_BYTES) : elem_bytes_r;
    for (int k = 0; k < gxve_pkg::MAX_BYTES; k++) begin
      value_mask[k*8 +: 8] = (gxve_pkg::ELEM_BYTES_W'(k) < bytes_clamped) ? 8'hFF : 8'h00;
    end
  end

  assign xor_val = s1_value_r ^ prev_value_r;

  // leading zero count: highest set bit wins
  always_comb begin
    lead = '0;
    for (int i = 0; i < WB; i++) begin
      if (xor_val[i]) begin
        lead = LW'(WB - 1 - i);
      end
    end
  end

  // trailing zero count: lowest set bit wins
  always_comb begin
    trail = '0;
    for (int i = WB - 1; i >= 0; i--) begin
      if (xor_val[i]) begin
        trail = LW'(i);
      end
    end
  end

  assign mbits       = gxve_pkg::FULL_COUNT - {1'b0, lead} - {1'b0, trail};
  assign top_end     = gxve_pkg::FULL_COUNT - {1'b0, trail};
  assign win_end     = {1'b0, win_lead_r} + win_bits_r;
  assign reuse_shift = gxve_pkg::FULL_COUNT - win_end;
  assign fits        = (win_bits_r != '0) && (lead >= win_lead_r) &&
                       (top_end <= win_end) && (win_end <= gxve_pkg::FULL_COUNT);

  always_comb begin
    res_nxt        = '0;
    prev_value_nxt = s1_value_r;
    win_lead_nxt   = win_lead_r;
    win_bits_nxt   = win_bits_r;
    if (s1_start_r) begin
      res_nxt.raw_first = 1'b1;
      res_nxt.bit_count = gxve_pkg::FULL_COUNT;
      res_nxt.payload   = s1_value_r;
      win_lead_nxt      = '0;
      win_bits_nxt      = '0;
    end else if (xor_val != '0) begin
      res_nxt.changed = 1'b1;
      if (fits) begin
        // bits above the window are already zero, no mask needed
        res_nxt.bit_count = win_bits_r;
        res_nxt.payload   = xor_val >> reuse_shift[LW-1:0];
      end else begin
        res_nxt.new_window    = 1'b1;
        res_nxt.leading_zeros = lead;
        res_nxt.bit_count     = mbits;
        res_nxt.payload       = xor_val >> trail;
        win_lead_nxt          = lead;
        win_bits_nxt          = mbits;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elem_bytes_r <= gxve_pkg::ELEM_BYTES_RESET;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      prev_value_r <= '0;
      win_lead_r   <= '0;
      win_bits_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        elem_bytes_r <= cfg_wr_data;
      end
      if (s1_load) begin
        s1_valid_r <= 1'b1;
      end else if (s2_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s2_adv) begin
        out_valid_r  <= 1'b1;
        prev_value_r <= prev_value_nxt;
        win_lead_r   <= win_lead_nxt;
        win_bits_r   <= win_bits_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_value_r <= in_tdata & value_mask;
      s1_start_r <= in_tuser;
    end
    if (s2_adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = {res_r.new_window, res_r.changed, res_r.raw_first};
  assign out_tdata  = {{gxve_pkg::OUT_PAD_W{1'b0}}, res_r.payload, res_r.bit_count,
                       res_r.leading_zeros};

endmodule

// ===== rtl/gxve_checker.sv =====
// port-level checker for the gorilla xor value encoder, with its bind
`timescale 1ns / 1ps
`include "gorilla_xor_value_encoder_defines.svh"

module gxve_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [gxve_pkg::OUT_DATA_W-1:0]   out_tdata,
  input logic [gxve_pkg::OUT_USER_W-1:0]   out_tuser
);

  logic       raw_first;
  logic       changed;
  logic       new_window;
  logic [5:0] lead_f;
  logic [6:0] count_f;
  logic [7:0] span;

  assign raw_first  = out_tuser[0];
  assign changed    = out_tuser[1];
  assign new_window = out_tuser[2];
  assign lead_f     = out_tdata[5:0];
  assign count_f    = out_tdata[12:6];
  assign span       = {2'b00, lead_f} + {1'b0, count_f};

  // a stalled result beat holds
  `GXVE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result beat changed while stalled")

  // raw beat carries no tags and a full count
  `GXVE_ASSERT_NOW(a_raw_form, clk, rst_n, out_tvalid && raw_first, !changed && !new_window && lead_f == 6'd0 && count_f == gxve_pkg::FULL_COUNT, "malformed raw beat")

  // unchanged beat is all zero
  `GXVE_ASSERT_NOW(a_unchanged_zero, clk, rst_n, out_tvalid && !raw_first && !changed, !new_window && out_tdata == '0, "unchanged beat carries data")

  // a new window fits the word and is never empty
  `GXVE_ASSERT_NOW(a_new_window_span, clk, rst_n, out_tvalid && new_window, changed && !raw_first && count_f != 7'd0 && span <= 8'd64, "new window out of range")

  // a reused window has a count and no leading field
  `GXVE_ASSERT_NOW(a_reuse_form, clk, rst_n, out_tvalid && changed && !new_window, lead_f == 6'd0 && count_f != 7'd0 && !raw_first, "malformed window reuse beat")

endmodule

bind gorilla_xor_value_encoder gxve_checker u_gxve_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
